### hw/rtl/grid_dfs_path_search_core_defines.svh
// Assertion helpers used by the grid search datapath.
`ifndef GRID_DFS_PATH_SEARCH_CORE_DEFINES_SVH
`define GRID_DFS_PATH_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define GDFS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdfs: implication violated");

// Next-cycle implication, masked during reset.
`define GDFS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdfs: next-cycle implication violated");

// Condition that must never hold.
`define GDFS_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("gdfs: forbidden condition seen");

`endif

### hw/rtl/gdfs_pkg.sv
package gdfs_pkg;

  // Fixed geometry of the wall grid and cell codes
  localparam int GRID_ROWS = 8;
  localparam int LINE_W    = 8;
  localparam int CELL_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_USED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_USED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LINE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_LINE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_POS   = 3'd5;

  // Last of the eight neighbour offsets
  localparam logic [2:0] NB_LAST = 3'd7;

  typedef enum logic [1:0] {
    OUT_FOUND    = 2'd0,
    OUT_NO_PATH  = 2'd1,
    OUT_OVERFLOW = 2'd2
  } outcome_e;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       start;
    logic [2:0] nb_idx;
    logic       push;
    logic       pop;
    logic       fetch;
    logic       mark_goal;
    logic       set_outcome;
    outcome_e   outcome;
    logic [2:0] row_idx;
  } gdfs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic nb_goal;
    logic nb_push;
    logic stack_full;
    logic stack_empty;
    logic last_row;
  } gdfs_sts_t;

  // Line delta of neighbour k; position delta is the outer loop
  function automatic logic [3:0] nb_dline(logic [2:0] k);
    logic [3:0] d;
    if (k inside {3'd0, 3'd3, 3'd5}) begin
      d = 4'hF;
    end else if (k inside {3'd1, 3'd6}) begin
      d = 4'h0;
    end else begin
      d = 4'h1;
    end
    return d;
  endfunction

  // Position delta of neighbour k
  function automatic logic [3:0] nb_dpos(logic [2:0] k);
    logic [3:0] d;
    if (k inside {[3'd0:3'd2]}) begin
      d = 4'hF;
    end else if (k inside {3'd3, 3'd4}) begin
      d = 4'h0;
    end else begin
      d = 4'h1;
    end
    return d;
  endfunction

endpackage

### hw/rtl/gdfs_line_if.sv
// Wall line channel
interface gdfs_line_if import gdfs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_walls;
  logic              final_line;

  modport source (output valid, line_walls, final_line, input ready);
  modport sink   (input valid, line_walls, final_line, output ready);
endinterface

### hw/rtl/gdfs_mark_if.sv
// Mark row channel
interface gdfs_mark_if import gdfs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_marks;
  logic [1:0]        outcome;
  logic              last_result;

  modport source (output valid, line_marks, outcome, last_result, input ready);
  modport sink   (input valid, line_marks, outcome, last_result, output ready);
endinterface

### hw/rtl/gdfs_ctrl.sv
module gdfs_ctrl import gdfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_final_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  gdfs_sts_t sts_i,
  output gdfs_cmd_t cmd_o
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] nb_q, nb_d;
  logic [2:0] row_q, row_d;

  // Sequencer: load lines, scan neighbours, pop and fetch, emit rows
  always_comb begin
    state_d        = state_q;
    nb_d           = nb_q;
    row_d          = row_q;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    cmd_o          = '0;
    cmd_o.nb_idx   = nb_q;
    cmd_o.row_idx  = row_q;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_final_i) begin
            cmd_o.start = 1'b1;
            nb_d        = '0;
            state_d     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.nb_goal) begin
          cmd_o.mark_goal   = 1'b1;
          cmd_o.set_outcome = 1'b1;
          cmd_o.outcome     = OUT_FOUND;
          row_d             = '0;
          state_d           = S_EMIT;
        end else if (sts_i.nb_push && sts_i.stack_full) begin
          cmd_o.set_outcome = 1'b1;
          cmd_o.outcome     = OUT_OVERFLOW;
          row_d             = '0;
          state_d           = S_EMIT;
        end else begin
          cmd_o.push = sts_i.nb_push;
          if (nb_q == NB_LAST) begin
            if (sts_i.stack_empty && !sts_i.nb_push) begin
              cmd_o.set_outcome = 1'b1;
              cmd_o.outcome     = OUT_NO_PATH;
              row_d             = '0;
              state_d           = S_EMIT;
            end else begin
              state_d = S_POP;
            end
          end else begin
            nb_d = nb_q + 3'd1;
          end
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_FETCH;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        nb_d        = '0;
        state_d     = S_SCAN;
      end
      S_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.last_row) begin
            row_d   = '0;
            state_d = S_LOAD;
          end else begin
            row_d = row_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      nb_q    <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      nb_q    <= nb_d;
      row_q   <= row_d;
    end
  end

endmodule

### hw/rtl/gdfs_dpath.sv
`include "grid_dfs_path_search_core_defines.svh"

module gdfs_dpath import gdfs_pkg::*; #(
  parameter int GRID_SIZE   = 8,
  parameter int STACK_DEPTH = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gdfs_cmd_t            cmd_i,
  output gdfs_sts_t            sts_o,
  input  logic [LINE_W-1:0]    line_walls_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic [LINE_W-1:0]    line_marks_o,
  output logic [1:0]           outcome_o,
  output logic                 last_result_o
);

  localparam int LineCap = (GRID_SIZE < GRID_ROWS) ? GRID_SIZE : GRID_ROWS;
  localparam int LvlW    = $clog2(STACK_DEPTH + 1);
  localparam int AddrW   = $clog2(STACK_DEPTH);

  // Configuration registers
  logic [3:0] lines_used_q, width_used_q;
  logic [2:0] start_line_q, start_pos_q, goal_line_q, goal_pos_q;

  // Search state
  logic [LINE_W-1:0] wall_q    [GRID_ROWS];
  logic [LINE_W-1:0] visited_q [GRID_ROWS];
  logic [LINE_W-1:0] visited_d [GRID_ROWS];
  logic [LINE_W-1:0] mark_q    [GRID_ROWS];
  logic [LINE_W-1:0] mark_d    [GRID_ROWS];
  logic [3:0]        load_cnt_q, load_cnt_d;
  logic [CELL_W-1:0] cur_q, cur_d;
  logic [LvlW-1:0]   level_q, level_d;
  logic [1:0]        outcome_q, outcome_d;

  // Cell stack memory
  logic [CELL_W-1:0] stack_mem [STACK_DEPTH];
  logic [CELL_W-1:0] stack_rd_q;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [LvlW-1:0]   level_dec;

  logic [3:0] nlines, nwidth;
  logic [3:0] nb_line, nb_pos;
  logic       nb_in, nb_open, nb_goal, nb_vis;
  logic [CELL_W-1:0] start_cell, nb_cell;
  logic [3:0] rows;
  logic [8:0] wmask;

  // Effective area in use
  assign nlines = (lines_used_q < 4'(LineCap)) ? lines_used_q : 4'(LineCap);
  assign nwidth = (width_used_q < 4'(LineCap)) ? width_used_q : 4'(LineCap);

  // Neighbour under test; negative offsets wrap high and fail the bound check
  assign nb_line = {1'b0, cur_q[5:3]} + nb_dline(cmd_i.nb_idx);
  assign nb_pos  = {1'b0, cur_q[2:0]} + nb_dpos(cmd_i.nb_idx);
  assign nb_in   = (nb_line < nlines) && (nb_pos < nwidth);
  assign nb_open = nb_in && !wall_q[nb_line[2:0]][nb_pos[2:0]];
  assign nb_vis  = visited_q[nb_line[2:0]][nb_pos[2:0]];
  assign nb_goal = nb_open && (nb_line[2:0] == goal_line_q) && (nb_pos[2:0] == goal_pos_q);
  assign nb_cell = {nb_line[2:0], nb_pos[2:0]};
  assign start_cell = {start_line_q, start_pos_q};

  assign sts_o.nb_goal     = nb_goal;
  assign sts_o.nb_push     = nb_open && !nb_goal && !nb_vis;
  assign sts_o.stack_full  = (level_q == LvlW'(STACK_DEPTH));
  assign sts_o.stack_empty = (level_q == '0);

  // Result rows
  assign rows          = (nlines == 4'd0) ? 4'd1 : nlines;
  assign sts_o.last_row = (({1'b0, cmd_i.row_idx} + 4'd1) == rows);
  assign wmask         = (9'd1 << nwidth) - 9'd1;
  assign line_marks_o  = ((outcome_q == OUT_FOUND) && ({1'b0, cmd_i.row_idx} < nlines))
                         ? (mark_q[cmd_i.row_idx] & wmask[LINE_W-1:0]) : '0;
  assign outcome_o     = outcome_q;
  assign last_result_o = sts_o.last_row;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_used_q <= 4'd5;
      width_used_q <= 4'd5;
      start_line_q <= 3'd0;
      start_pos_q  <= 3'd0;
      goal_line_q  <= 3'd4;
      goal_pos_q   <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINES_USED: lines_used_q <= cfg_data_i;
        CFG_WIDTH_USED: width_used_q <= cfg_data_i;
        CFG_START_LINE: start_line_q <= cfg_data_i[2:0];
        CFG_START_POS:  start_pos_q  <= cfg_data_i[2:0];
        CFG_GOAL_LINE:  goal_line_q  <= cfg_data_i[2:0];
        CFG_GOAL_POS:   goal_pos_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Wall lines, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (load_cnt_q < 4'(LineCap))) begin
      wall_q[load_cnt_q[2:0]] <= line_walls_i;
    end
  end

  assign level_dec = level_q - LvlW'(1);

  // Next state of counters, grids and current cell
  always_comb begin
    load_cnt_d = load_cnt_q;
    visited_d  = visited_q;
    mark_d     = mark_q;
    cur_d      = cur_q;
    level_d    = level_q;
    outcome_d  = outcome_q;
    mem_we     = 1'b0;
    mem_waddr  = level_q[AddrW-1:0];
    mem_wdata  = nb_cell;

    if (cmd_i.load) begin
      if (cmd_i.start) begin
        load_cnt_d = '0;
      end else if (load_cnt_q != 4'hF) begin
        load_cnt_d = load_cnt_q + 4'd1;
      end
    end

    if (cmd_i.start) begin
      // fresh grids, start cell on the stack and expanded first
      for (int r = 0; r < GRID_ROWS; r++) begin
        visited_d[r] = '0;
        mark_d[r]    = '0;
      end
      visited_d[start_line_q][start_pos_q] = 1'b1;
      mark_d[start_line_q][start_pos_q]    = 1'b1;
      cur_d     = start_cell;
      level_d   = LvlW'(1);
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = start_cell;
    end

    if (cmd_i.push) begin
      mem_we  = 1'b1;
      level_d = level_q + LvlW'(1);
    end

    if (cmd_i.mark_goal) begin
      mark_d[nb_line[2:0]][nb_pos[2:0]] = 1'b1;
    end

    if (cmd_i.pop) begin
      level_d = level_dec;
    end

    if (cmd_i.fetch) begin
      cur_d = stack_rd_q;
      visited_d[stack_rd_q[5:3]][stack_rd_q[2:0]] = 1'b1;
      mark_d[stack_rd_q[5:3]][stack_rd_q[2:0]]    = 1'b1;
    end

    if (cmd_i.set_outcome) begin
      outcome_d = cmd_i.outcome;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      visited_q  <= '{default: '0};
      mark_q     <= '{default: '0};
      cur_q      <= '0;
      level_q    <= '0;
      outcome_q  <= OUT_FOUND;
    end else begin
      load_cnt_q <= load_cnt_d;
      visited_q  <= visited_d;
      mark_q     <= mark_d;
      cur_q      <= cur_d;
      level_q    <= level_d;
      outcome_q  <= outcome_d;
    end
  end

  // Stack memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.pop) begin
      stack_rd_q <= stack_mem[level_dec[AddrW-1:0]];
    end
  end

  `GDFS_ASSERT_NEVER(a_level_bound, clk_i, rst_ni, level_q > LvlW'(STACK_DEPTH))
  `GDFS_ASSERT_IMPL(a_push_not_full, clk_i, rst_ni, cmd_i.push, level_q != LvlW'(STACK_DEPTH))
  `GDFS_ASSERT_IMPL(a_pop_not_empty, clk_i, rst_ni, cmd_i.pop, level_q != '0)
  `GDFS_ASSERT_NEXT(a_fetch_visits, clk_i, rst_ni, cmd_i.fetch, visited_q[cur_q[5:3]][cur_q[2:0]])

endmodule

### hw/rtl/grid_dfs_path_search_core.sv
// Depth-first maze search over an 8-neighbour wall grid. Wall lines are taken
// one item per cycle; the item with final_line set is stored as a line too and
// starts the search from the configured start cell. The search is data
// dependent and the input is not ready while it runs: the set-up is done at the
// edge that takes the final line, then each expansion scans its eight
// neighbours one per cycle and pops the next cell through the POP and FETCH
// states, reading it from the registered read port of the stack memory. The
// result is then sent as one mark row per line in use (one row when no line is
// in use), one row per cycle while the sink is ready, the last row flagged by
// last_result. Rows carry marks only when the goal was found; outcome tells
// found, no path or stack overflow. The user must write configuration
// registers only while idle; the block itself does not enforce it.
module grid_dfs_path_search_core import gdfs_pkg::*; #(
  parameter int GRID_SIZE   = 8,
  parameter int STACK_DEPTH = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  gdfs_line_if.sink            line_i,
  gdfs_mark_if.source          mark_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  gdfs_cmd_t cmd;
  gdfs_sts_t sts;

  // Sequencer
  gdfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (line_i.valid),
    .in_final_i  (line_i.final_line),
    .in_ready_o  (line_i.ready),
    .out_valid_o (mark_o.valid),
    .out_ready_i (mark_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Grids, stack and result rows
  gdfs_dpath #(
    .GRID_SIZE   (GRID_SIZE),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .line_walls_i  (line_i.line_walls),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .line_marks_o  (mark_o.line_marks),
    .outcome_o     (mark_o.outcome),
    .last_result_o (mark_o.last_result)
  );

endmodule

### tb/testbench.sv
module testbench import gdfs_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_SIZE   = 8;
  localparam int STACK_DEPTH = 128;
  localparam int LINE_CAP    = (GRID_SIZE < 8) ? GRID_SIZE : 8;
  localparam int IDLE_LIMIT  = 40000;
  localparam int SETTLE_CYC  = 20;
  localparam int ITEM_TARGET = 420;

  // One mark row as the block sends it
  typedef struct packed {
    logic [7:0] line_marks;
    outcome_e   outcome;
    logic       last_result;
  } mark_row_t;

  // Tracks the maze search and holds the mark rows still to come
  class mark_row_scoreboard;
    mark_row_t   expected_rows[$];
    int unsigned fail_count;

    bit [7:0] wall_q    [8];
    bit [7:0] visited_q [8];
    bit [7:0] marked_q  [8];
    bit [5:0] cell_stack [STACK_DEPTH];
    int       stack_lvl;
    bit [5:0] cur_cell;
    int       load_cnt;

    bit [3:0] lines_used, width_used;
    bit [2:0] start_line, start_pos, goal_line, goal_pos;

    function new();
      lines_used = 4'd5;
      width_used = 4'd5;
      start_line = 3'd0;
      start_pos  = 3'd0;
      goal_line  = 3'd4;
      goal_pos   = 3'd4;
      load_cnt   = 0;
      fail_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_LINES_USED: lines_used = data;
        CFG_WIDTH_USED: width_used = data;
        CFG_START_LINE: start_line = data[2:0];
        CFG_START_POS:  start_pos  = data[2:0];
        CFG_GOAL_LINE:  goal_line  = data[2:0];
        CFG_GOAL_POS:   goal_pos   = data[2:0];
        default: ;
      endcase
    endfunction

    function int used_dim(bit [3:0] v);
      return (v < LINE_CAP) ? int'(v) : LINE_CAP;
    endfunction

    // Stack search from the start cell; leaves the marks in marked_q
    function outcome_e search_maze();
      int       lines_n, width_n, cl, cp, dp, dl, nl, np;
      bit       done;
      outcome_e res;
      lines_n = used_dim(lines_used);
      width_n = used_dim(width_used);
      visited_q = '{default: '0};
      marked_q  = '{default: '0};
      cell_stack[0] = {start_line, start_pos};
      stack_lvl = 1;
      cur_cell  = {start_line, start_pos};
      marked_q[start_line][start_pos] = 1'b1;
      done = 1'b0;
      res  = OUT_NO_PATH;
      while (!done) begin
        cl = cur_cell[5:3];
        cp = cur_cell[2:0];
        visited_q[cl][cp] = 1'b1;
        // position delta outer, line delta inner
        for (dp = -1; dp <= 1 && !done; dp++) begin
          for (dl = -1; dl <= 1 && !done; dl++) begin
            nl = cl + dl;
            np = cp + dp;
            if (!(dl == 0 && dp == 0) && nl >= 0 && np >= 0 &&
                nl < lines_n && np < width_n && !wall_q[nl][np]) begin
              if (nl == goal_line && np == goal_pos) begin
                marked_q[nl][np] = 1'b1;
                res  = OUT_FOUND;
                done = 1'b1;
              end else if (!visited_q[nl][np]) begin
                if (stack_lvl >= STACK_DEPTH) begin
                  res  = OUT_OVERFLOW;
                  done = 1'b1;
                end else begin
                  cell_stack[stack_lvl] = {nl[2:0], np[2:0]};
                  stack_lvl++;
                end
              end
            end
          end
        end
        if (!done) begin
          if (stack_lvl == 0) begin
            res  = OUT_NO_PATH;
            done = 1'b1;
          end else begin
            stack_lvl--;
            cur_cell = cell_stack[stack_lvl];
            marked_q[cur_cell[5:3]][cur_cell[2:0]] = 1'b1;
          end
        end
      end
      return res;
    endfunction

    // Accepted wall line; a final one runs the search and queues the rows
    function void note_line(logic [7:0] walls, logic fin);
      outcome_e  res;
      int        lines_n, rows, k;
      bit [7:0]  wmask;
      mark_row_t row;
      if (load_cnt < LINE_CAP) wall_q[load_cnt] = walls;
      if (load_cnt < 15) load_cnt++;
      if (!fin) return;
      load_cnt = 0;
      res     = search_maze();
      lines_n = used_dim(lines_used);
      wmask   = 8'((1 << used_dim(width_used)) - 1);
      rows    = (lines_n == 0) ? 1 : lines_n;
      for (k = 0; k < rows; k++) begin
        row.line_marks  = (res == OUT_FOUND && k < lines_n) ? (marked_q[k] & wmask) : 8'h00;
        row.outcome     = res;
        row.last_result = (k + 1 == rows);
        expected_rows.push_back(row);
      end
    endfunction

    function void check_row(logic [7:0] marks, logic [1:0] outc, logic last);
      mark_row_t want;
      if (expected_rows.size() == 0) begin
        $error("unexpected mark row: line_marks %02h outcome %0d last_result %0b",
               marks, outc, last);
        fail_count++;
        return;
      end
      want = expected_rows.pop_front();
      if (want.line_marks !== marks) begin
        $error("line_marks: expected %02h, actual %02h", want.line_marks, marks);
        fail_count++;
      end
      if (want.outcome !== outc) begin
        $error("outcome: expected %0d, actual %0d", want.outcome, outc);
        fail_count++;
      end
      if (want.last_result !== last) begin
        $error("last_result: expected %0b, actual %0b", want.last_result, last);
        fail_count++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  gdfs_line_if line_if ();
  gdfs_mark_if mark_if ();

  grid_dfs_path_search_core #(
    .GRID_SIZE  (GRID_SIZE),
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .line_i    (line_if),
    .mark_o    (mark_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  mark_row_scoreboard sb = new();

  int items_sent = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int stall_tick = 0;
  int idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver back-pressure: four random modes that switch when stall_left runs out
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    if (!rst_ni) begin
      mark_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       mark_if.ready <= 1'b1;
        1:       mark_if.ready <= 1'($urandom_range(0, 1));
        2:       mark_if.ready <= ($urandom_range(0, 3) == 0);
        default: mark_if.ready <= (stall_tick % 3 == 0);
      endcase
    end
  end

  // Watch both channels
  always @(posedge clk_i) begin
    if (rst_ni && line_if.valid && line_if.ready) begin
      sb.note_line(line_if.line_walls, line_if.final_line);
    end
    if (rst_ni && mark_if.valid && mark_if.ready) begin
      sb.check_row(mark_if.line_marks, mark_if.outcome, mark_if.last_result);
    end
  end

  // Give up when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (line_if.valid && line_if.ready) || (mark_if.valid && mark_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one wall line; bursts of items with random gaps between them
  task automatic send_line(input logic [7:0] walls, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        line_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    line_if.valid      <= 1'b1;
    line_if.line_walls <= walls;
    line_if.final_line <= fin;
    do @(posedge clk_i); while (!line_if.ready);
    burst_left--;
    items_sent++;
  endtask

  // Hold the sender until all rows are back and the block has settled
  task automatic wait_idle();
    line_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Write all six registers, only ever called while idle
  task automatic load_config(input bit [3:0] lines, input bit [3:0] width,
                             input bit [2:0] sline, input bit [2:0] spos,
                             input bit [2:0] gline, input bit [2:0] gpos);
    logic [CFG_IDX_W-1:0] idx_list [6];
    logic [CFG_W-1:0]     val_list [6];
    int                   i;
    idx_list = '{CFG_LINES_USED, CFG_WIDTH_USED, CFG_START_LINE,
                 CFG_START_POS, CFG_GOAL_LINE, CFG_GOAL_POS};
    val_list = '{lines, width, {1'b0, sline}, {1'b0, spos}, {1'b0, gline}, {1'b0, gpos}};
    for (i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx_list[i];
      cfg_data_i <= val_list[i];
      @(posedge clk_i);
      sb.set_reg(idx_list[i], val_list[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_walls(int density);
    case (density)
      0:       return 8'h00;
      1:       return 8'($urandom & $urandom & $urandom);
      2:       return 8'($urandom);
      default: return 8'($urandom | $urandom);
    endcase
  endfunction

  // Mostly small sizes, now and then zero or beyond the cap
  function automatic bit [3:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 4'd0;
      1:       return 4'd1;
      2:       return 4'd8;
      3:       return 4'($urandom_range(9, 15));
      default: return 4'($urandom_range(2, 8));
    endcase
  endfunction

  task automatic send_maze(input int n_lines, input int density);
    int i;
    for (i = 0; i < n_lines; i++) begin
      send_line(pick_walls(density), i == n_lines - 1);
    end
  endtask

  initial begin
    int       i, n, searches, lines_n, density;
    bit [3:0] lines, width;
    bit [2:0] sline, spos, gline, gpos;

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_LINES_USED;
    cfg_data_i         <= '0;
    line_if.valid      <= 1'b0;
    line_if.line_walls <= '0;
    line_if.final_line <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings, all eight lines loaded so none is left unwritten
    for (i = 0; i < 8; i++) send_line((i == 7) ? 8'hFF : 8'h00, i == 7);
    wait_idle();

    // Full grid, start on a wall in the far corner, goal at the origin
    load_config(4'd8, 4'd8, 3'd7, 3'd7, 3'd0, 3'd0);
    send_line(8'h00, 1'b1);
    wait_idle();

    // No line and no cell in use
    load_config(4'd0, 4'd0, 3'd0, 3'd0, 3'd0, 3'd0);
    send_line(8'h5A, 1'b1);
    wait_idle();

    // Sizes beyond the cap, goal equal to start, first line all walls
    load_config(4'd15, 4'd15, 3'd3, 3'd3, 3'd3, 3'd3);
    send_line(8'hFF, 1'b1);
    wait_idle();

    // Start boxed in by walls: no path
    load_config(4'd8, 4'd8, 3'd0, 3'd0, 3'd7, 3'd7);
    send_line(8'h02, 1'b0);
    send_line(8'h03, 1'b1);
    wait_idle();

    // Open grid with goal out of reach fills the stack; extra lines ignored
    load_config(4'd8, 4'd7, 3'd0, 3'd0, 3'd7, 3'd7);
    for (i = 0; i < 10; i++) send_line((i >= 8) ? 8'hFF : 8'h00, i == 9);
    wait_idle();

    // Random phases: new settings, then a few searches each
    while (items_sent < ITEM_TARGET) begin
      lines = pick_dim();
      width = pick_dim();
      lines_n = (lines < LINE_CAP) ? lines : LINE_CAP;
      sline = ($urandom_range(0, 4) == 0) ? 3'($urandom) :
              3'($urandom_range(0, (lines_n > 0) ? lines_n - 1 : 0));
      spos  = ($urandom_range(0, 4) == 0) ? 3'($urandom) :
              3'($urandom_range(0, (width > 1) ? ((width < 8) ? width - 1 : 7) : 0));
      case ($urandom_range(0, 5))
        0: begin
          gline = sline;
          gpos  = spos;
        end
        1: begin
          gline = 3'($urandom);
          gpos  = 3'($urandom);
        end
        default: begin
          gline = 3'($urandom_range(0, (lines_n > 0) ? lines_n - 1 : 0));
          gpos  = 3'($urandom_range(0, (width > 1) ? ((width < 8) ? width - 1 : 7) : 0));
        end
      endcase
      load_config(lines, width, sline, spos, gline, gpos);

      searches = $urandom_range(1, 4);
      repeat (searches) begin
        if ($urandom_range(0, 4) == 0) begin
          n = $urandom_range(1, 11);
        end else begin
          n = (lines_n > 0) ? lines_n : $urandom_range(1, 3);
        end
        density = $urandom_range(0, 3);
        send_maze(n, density);
        if ($urandom_range(0, 5) == 0) wait_idle();
      end
      wait_idle();
    end

    wait_idle();
    if (sb.fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
